// File: sv/qsh_pkg.sv
// Shared constants and types for the quicksort sorter core.
package qsh_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    // One value slot moving between neighboring cells.
    typedef struct packed {
        logic                    vld;
        logic signed [VAL_W-1:0] val;
    } qsh_link_t;

    // Per-cycle control broadcast to every cell.
    typedef struct packed {
        logic shift;   // move held values one cell toward the output
    } qsh_ctrl_t;

endpackage

// File: sv/qsh_cell.sv
// One sorting cell: keeps the smaller value, hands the larger one to the right.
module qsh_cell
    import qsh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  qsh_ctrl_t ctrl,
    input  qsh_link_t carry_in,   // value arriving from the left neighbor
    input  qsh_link_t right_held, // held value of the right neighbor (drain shift)
    output qsh_link_t held,
    output qsh_link_t carry_out   // value handed to the right neighbor
);

    logic                    held_vld_reg;
    logic                    held_vld_next;
    logic signed [VAL_W-1:0] held_val_reg;
    logic signed [VAL_W-1:0] held_val_next;
    logic                    carry_vld_reg;
    logic                    carry_vld_next;
    logic signed [VAL_W-1:0] carry_val_reg;
    logic signed [VAL_W-1:0] carry_val_next;

    always_comb
    begin
        held_vld_next  = held_vld_reg;
        held_val_next  = held_val_reg;
        carry_vld_next = 1'b0;
        carry_val_next = carry_val_reg;
        if (ctrl.shift)
        begin
            held_vld_next = right_held.vld;
            held_val_next = right_held.val;
        end
        else if (carry_in.vld)
        begin
            if (!held_vld_reg || (carry_in.val < held_val_reg))
            begin
                // new value takes the slot, old one (if any) moves on
                held_vld_next  = 1'b1;
                held_val_next  = carry_in.val;
                carry_vld_next = held_vld_reg;
                carry_val_next = held_val_reg;
            end
            else
            begin
                carry_vld_next = 1'b1;
                carry_val_next = carry_in.val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_vld_reg  <= 1'b0;
            carry_vld_reg <= 1'b0;
        end
        else
        begin
            held_vld_reg  <= held_vld_next;
            carry_vld_reg <= carry_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_val_reg  <= held_val_next;
        carry_val_reg <= carry_val_next;
    end

    assign held.vld      = held_vld_reg;
    assign held.val      = held_val_reg;
    assign carry_out.vld = carry_vld_reg;
    assign carry_out.val = carry_val_reg;

endmodule

// File: sv/quicksort_hoare_sorter_core.sv
// Top level of the sorter core: cell chain plus load/settle/drain control.
// The core collects a set of signed 32-bit values, one per input item, and
// returns them in ascending order. The set is closed by the item carrying
// final_item; up to MAX_ITEMS (64) values are kept, and any beyond that are
// dropped, in which case every result of that set carries overflow. Sorting
// is done by a chain of MAX_ITEMS cells: a value entering at cell 0 ripples
// right one cell per cycle, each cell keeping the smaller of its held value
// and the arriving one, so insertion overlaps with loading. A set goes
// through loading (one item per cycle), then a settle phase while the last
// insertion wave travels down the chain, then output, one result per cycle
// when the consumer does not stall. The last result carries final_result.
// Input is stalled from the final item until the last result of the set is
// taken; the output payload comes straight from cell 0 and holds while
// stalled.
module quicksort_hoare_sorter_core
    import qsh_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [VAL_W-1:0] value,
    input  logic                    final_item,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [VAL_W-1:0] sorted_value,
    output logic                    final_result,
    output logic                    overflow
);

    typedef enum logic [2:0] {
        ST_LOAD   = 3'b001,
        ST_SETTLE = 3'b010,
        ST_DRAIN  = 3'b100
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             dropped_reg;
    logic             dropped_next;

    qsh_link_t           carry [0:MAX_ITEMS];
    qsh_link_t           held  [0:MAX_ITEMS];
    logic [MAX_ITEMS:1]  carry_vld_vec;
    qsh_ctrl_t           ctrl;

    logic in_acc;
    logic out_acc;
    logic store_ok;
    logic any_carry;

    assign in_stall = (state_reg != ST_LOAD);
    assign in_acc   = in_valid && !in_stall;
    assign store_ok = (count_reg < CNT_W'(MAX_ITEMS));

    // result comes straight from the head cell
    assign out_valid    = (state_reg == ST_DRAIN) && held[0].vld;
    assign out_acc      = out_valid && !out_stall;
    assign sorted_value = held[0].val;
    assign final_result = !held[1].vld;
    assign overflow     = dropped_reg;

    // injection into the head of the chain
    assign carry[0].vld = in_acc && store_ok;
    assign carry[0].val = value;

    // tail cell shifts in an empty slot during drain
    assign held[MAX_ITEMS].vld = 1'b0;
    assign held[MAX_ITEMS].val = '0;

    assign ctrl.shift = out_acc;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++)
        begin : g_cell
            qsh_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .carry_in   (carry[gi]),
                .right_held (held[gi+1]),
                .held       (held[gi]),
                .carry_out  (carry[gi+1])
            );
            assign carry_vld_vec[gi+1] = carry[gi+1].vld;
        end
    endgenerate

    assign any_carry = |carry_vld_vec;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (store_ok)
                        count_next = count_reg + CNT_W'(1);
                    else
                        dropped_next = 1'b1;
                    if (final_item)
                        state_next = ST_SETTLE;
                end
            end
            ST_SETTLE:
            begin
                // wait for the last insertion wave to come to rest
                if (!any_carry)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (out_acc && final_result)
                begin
                    state_next   = ST_LOAD;
                    count_next   = '0;
                    dropped_next = 1'b0;
                end
            end
            default:
            begin
                state_next   = ST_LOAD;
                count_next   = '0;
                dropped_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    // nothing ever falls off the end of the chain
    a_no_tail_spill: assert property (@(posedge clk) disable iff (!rst_n)
        !carry[MAX_ITEMS].vld)
        else $error("value pushed past the last cell");

    // fill count never exceeds the chain length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("fill count beyond chain length");

    // results are only offered once the chain has settled
    a_drain_settled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !any_carry)
        else $error("result offered while insertion still in flight");

    // taking the last result reopens the core for a new set
    a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && final_result) |=> (state_reg == ST_LOAD) && (count_reg == '0)
            && !held[0].vld)
        else $error("core not cleared after last result");

endmodule

// File: dv/quicksort_hoare_sorter_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for quicksort_hoare_sorter_core against a sort predictor.
module quicksort_hoare_sorter_core_test
    import qsh_pkg::*;
();

    // One input item waiting to be driven. A set that must start on an idle
    // block has hold_for_drain on its first item.
    typedef struct {
        logic signed [VAL_W-1:0] val;
        logic                    fin;
        bit                      hold_for_drain;
    } feed_item_t;

    // One sorted result as the block should produce it.
    typedef struct {
        logic signed [VAL_W-1:0] val;
        logic                    fin;
        logic                    ovf;
    } sorted_out_t;

    localparam int IDLE_LIMIT = 4000;   // cycles with no item accepted on either side
    localparam int TAIL_WAIT  = 200;    // settle plus drain of a full set, with margin
    localparam int LONG_HOLD  = 300;    // one long receiver hold-off

    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    in_valid     = 1'b0;
    logic                    in_stall;
    logic signed [VAL_W-1:0] value        = '0;
    logic                    final_item   = 1'b0;
    logic                    out_valid;
    logic                    out_stall    = 1'b0;
    logic signed [VAL_W-1:0] sorted_value;
    logic                    final_result;
    logic                    overflow;

    feed_item_t  value_feed[$];    // items not yet driven
    sorted_out_t due_sorted[$];    // results not yet seen, oldest first

    // Predictor state: the current set, kept in ascending order as it fills.
    logic signed [VAL_W-1:0] set_sorted [MAX_ITEMS];
    int                      set_count   = 0;
    bit                      set_dropped = 1'b0;

    int errors        = 0;
    int items_in      = 0;
    int results_seen  = 0;
    int sets_closed   = 0;
    int overflow_sets = 0;
    int idle_cycles   = 0;

    quicksort_hoare_sorter_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .value        (value),
        .final_item   (final_item),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sorted_value (sorted_value),
        .final_result (final_result),
        .overflow     (overflow)
    );

    always #1 clk = ~clk;

    // Predictor: store the accepted value in its sorted place while there is
    // room, otherwise note the drop. The final item closes the set and puts
    // every stored value on the expected list; the last one carries the final
    // mark and all of them carry the drop flag of the set. The order that
    // quicksort leaves is just ascending order, so an insertion keeps it.
    task automatic insert_value(input logic signed [VAL_W-1:0] v, input logic fin);
        int          k;
        sorted_out_t res;
        if (set_count < MAX_ITEMS)
        begin
            k = set_count;
            while (k > 0 && set_sorted[k-1] > v)
            begin
                set_sorted[k] = set_sorted[k-1];
                k--;
            end
            set_sorted[k] = v;
            set_count++;
        end
        else
        begin
            set_dropped = 1'b1;   // store full: value (even a final one) is lost
        end
        if (fin)
        begin
            for (k = 0; k < set_count; k++)
            begin
                res.val = set_sorted[k];
                res.fin = (k == set_count - 1);
                res.ovf = set_dropped;
                due_sorted.push_back(res);
            end
            sets_closed++;
            if (set_dropped)
                overflow_sets++;
            set_count   = 0;
            set_dropped = 1'b0;
        end
    endtask

    task automatic push_value(input logic signed [VAL_W-1:0] v, input logic fin,
                              input bit hold);
        feed_item_t it;
        it.val            = v;
        it.fin            = fin;
        it.hold_for_drain = hold;
        value_feed.push_back(it);
    endtask

    // Random set of the given size. Flavor 0: full 32-bit values; 1: a narrow
    // band so duplicates are common; 2: extremes mixed with random values.
    task automatic queue_set(input int size, input int flavor, input bit hold);
        int                      k;
        logic signed [VAL_W-1:0] v;
        for (k = 0; k < size; k++)
        begin
            case (flavor)
                0: v = $urandom;
                1: v = $signed($urandom_range(0, 6)) - 3;
                default:
                    case ($urandom_range(0, 4))
                        0: v = 32'sh7FFF_FFFF;
                        1: v = 32'sh8000_0000;
                        2: v = 0;
                        3: v = -1;
                        default: v = $urandom;
                    endcase
            endcase
            push_value(v, k == size - 1, hold && k == 0);
        end
    endtask

    // Stimulus and end of run.
    initial
    begin
        int n_sets;
        int size;

        // Directed sets: lone extremes, a mix of extremes, duplicates,
        // presorted, reversed and a two-value set.
        push_value(32'sh7FFF_FFFF, 1'b1, 1'b0);
        push_value(32'sh8000_0000, 1'b1, 1'b0);
        push_value(32'sh7FFF_FFFF, 1'b0, 1'b0);
        push_value(32'sh8000_0000, 1'b0, 1'b0);
        push_value(0,              1'b0, 1'b0);
        push_value(-1,             1'b0, 1'b0);
        push_value(1,              1'b1, 1'b0);
        for (int k = 0; k < 4; k++)
            push_value(5, k == 3, 1'b0);
        for (int k = -3; k <= 2; k++)
            push_value(k, k == 2, 1'b0);
        for (int k = 3; k >= 1; k--)
            push_value(k, k == 1, 1'b0);
        push_value(7,  1'b0, 1'b0);
        push_value(-7, 1'b1, 1'b0);

        // Random sets, mostly small. Set 1 fills the store exactly; set 3
        // overruns it by three, so the final item itself is dropped too.
        // Sets 0 and 5 start only once every earlier result is back.
        n_sets = 0;
        while (n_sets < 6)
        begin
            if (n_sets == 1)
                size = MAX_ITEMS;
            else if (n_sets == 3)
                size = MAX_ITEMS + 3;
            else
                size = $urandom_range(1, 6);
            queue_set(size, $urandom_range(0, 2), n_sets == 0 || n_sets == 5);
            n_sets++;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (value_feed.size() > 0 || in_valid)
            @(posedge clk);
        while (due_sorted.size() > 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        $display("covered %0d sets from %0d items, %0d of them with dropped values,",
                 sets_closed, items_in, overflow_sets);
        $display("and checked %0d sorted results under bursty input and output stalls",
                 results_seen);
        if (errors == 0)
            $display("quicksort_hoare_sorter_core: match");
        else
            $display("quicksort_hoare_sorter_core: mismatch");
        $finish;
    end

    // Driver: bursts of random length separated by random gaps. The payload
    // only moves once the current item is taken. An item marked to wait for
    // drain is held back until no result is outstanding.
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk)
    begin
        feed_item_t nxt;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
            begin
                insert_value(value, final_item);
                items_in++;
            end
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (value_feed.size() > 0 &&
                     !(value_feed[0].hold_for_drain && due_sorted.size() > 0))
            begin
                nxt = value_feed.pop_front();
                value      <= nxt.val;
                final_item <= nxt.fin;
                in_valid   <= 1'b1;
                burst_left--;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: four patterns in turn, stepped by stall_phase (none, coin
    // flip, one in four, mostly stalled), plus one long hold-off in the
    // middle of a drain so the block backs up and stalls its input.
    logic [31:0] stall_phase     = '0;
    int          hold_left       = 0;
    bit          long_hold_done  = 1'b0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!long_hold_done && results_seen >= 40 && out_valid)
            begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                case (stall_phase[7:6])
                    2'd0:    out_stall <= 1'b0;
                    2'd1:    out_stall <= ($urandom_range(0, 1) == 0);
                    2'd2:    out_stall <= (stall_phase[1:0] == 2'd3);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Monitor: each taken result against the oldest expected one.
    always @(posedge clk)
    begin
        sorted_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (due_sorted.size() == 0)
            begin
                $error("result with none expected: sorted_value %0d", sorted_value);
                errors++;
            end
            else
            begin
                want = due_sorted.pop_front();
                if (sorted_value !== want.val)
                begin
                    $error("sorted_value: expected %0d, got %0d", want.val, sorted_value);
                    errors++;
                end
                if (final_result !== want.fin)
                begin
                    $error("final_result: expected %0b, got %0b", want.fin, final_result);
                    errors++;
                end
                if (overflow !== want.ovf)
                begin
                    $error("overflow: expected %0b, got %0b", want.ovf, overflow);
                    errors++;
                end
            end
        end
    end

    // Watchdog: too long without any item moving on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: %0d results still outstanding", due_sorted.size());
            $display("quicksort_hoare_sorter_core: mismatch");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
